>>> hdl/sshit_pkg.sv
package sshit_pkg;

   // Default coordinate width of the segment and center fields.
   localparam int COORD_BITS_DEF = 16;

   // The radius field has a fixed width, independent of the coordinates.
   localparam int RADIUS_BITS = 16;

   // Number of register stages from input acceptance to the result register.
   localparam int PIPE_STAGES = 8;

   // Decision flags that ride along with the arithmetic through the pipeline.
   typedef struct packed {
      logic d_zero;     // segment has zero length
      logic r_nonzero;  // radius is above zero
      logic proj_in;    // center projects onto the segment
      logic end_in;     // an endpoint lies strictly inside the sphere
   } flags_type;

endpackage

>>> hdl/sshit_req_if.sv
interface sshit_req_if #(
   parameter int COORD_BITS = sshit_pkg::COORD_BITS_DEF
);
   import sshit_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [COORD_BITS-1:0]  seg_start_x;
   logic signed [COORD_BITS-1:0]  seg_start_y;
   logic signed [COORD_BITS-1:0]  seg_start_z;
   logic signed [COORD_BITS-1:0]  seg_end_x;
   logic signed [COORD_BITS-1:0]  seg_end_y;
   logic signed [COORD_BITS-1:0]  seg_end_z;
   logic signed [COORD_BITS-1:0]  center_x;
   logic signed [COORD_BITS-1:0]  center_y;
   logic signed [COORD_BITS-1:0]  center_z;
   logic        [RADIUS_BITS-1:0] radius;

   modport source (
      output valid, seg_start_x, seg_start_y, seg_start_z,
             seg_end_x, seg_end_y, seg_end_z,
             center_x, center_y, center_z, radius,
      input  ready
   );

   modport sink (
      input  valid, seg_start_x, seg_start_y, seg_start_z,
             seg_end_x, seg_end_y, seg_end_z,
             center_x, center_y, center_z, radius,
      output ready
   );

endinterface

>>> hdl/sshit_rsp_if.sv
interface sshit_rsp_if;

   logic valid;
   logic ready;
   logic hit;

   modport source (
      output valid, hit,
      input  ready
   );

   modport sink (
      input  valid, hit,
      output ready
   );

endinterface

>>> hdl/sshit_datapath.sv
module sshit_datapath #(
   parameter int COORD_BITS = sshit_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic [sshit_pkg::PIPE_STAGES-1:0]   stage_en,
   input  logic signed [COORD_BITS-1:0]        seg_start_x,
   input  logic signed [COORD_BITS-1:0]        seg_start_y,
   input  logic signed [COORD_BITS-1:0]        seg_start_z,
   input  logic signed [COORD_BITS-1:0]        seg_end_x,
   input  logic signed [COORD_BITS-1:0]        seg_end_y,
   input  logic signed [COORD_BITS-1:0]        seg_end_z,
   input  logic signed [COORD_BITS-1:0]        center_x,
   input  logic signed [COORD_BITS-1:0]        center_y,
   input  logic signed [COORD_BITS-1:0]        center_z,
   input  logic [sshit_pkg::RADIUS_BITS-1:0]   radius,
   output logic                                hit
);
   import sshit_pkg::*;

   // Widths of the intermediate values.
   localparam int DFW = COORD_BITS + 1;        // coordinate differences
   localparam int PW  = 2 * COORD_BITS + 2;    // products of two differences
   localparam int SW  = 2 * COORD_BITS + 4;    // dot products
   localparam int KSW = 2 * COORD_BITS + 3;    // cross product components
   localparam int KW  = 2 * COORD_BITS + 2;    // cross component magnitudes
   localparam int KL  = (KW + 1) / 2;          // low half of a magnitude
   localparam int KH  = KW - KL;               // high half of a magnitude
   localparam int QW  = 2 * KW;                // squared cross component
   localparam int C2W = QW + 2;                // squared cross product length
   localparam int DW  = 2 * COORD_BITS + 2;    // squared vector lengths
   localparam int DL  = (DW + 1) / 2;
   localparam int DH  = DW - DL;
   localparam int R2W = 2 * RADIUS_BITS;       // squared radius
   localparam int EW  = (DW > R2W) ? DW : R2W; // endpoint compare width
   localparam int LW  = R2W + DW;              // radius limit r^2 * |d|^2
   localparam int CW  = (C2W > LW) ? C2W : LW; // final compare width

   // Stage 1: difference vectors d = E - S, t = C - S, u = C - E.
   logic signed [DFW-1:0]   d_ff [3], d_in [3];
   logic signed [DFW-1:0]   t_ff [3], t_in [3];
   logic signed [DFW-1:0]   u_ff [3], u_in [3];
   logic [RADIUS_BITS-1:0]  r1_ff, r1_in;

   always_comb begin
      d_in[0] = DFW'(seg_end_x) - DFW'(seg_start_x);
      d_in[1] = DFW'(seg_end_y) - DFW'(seg_start_y);
      d_in[2] = DFW'(seg_end_z) - DFW'(seg_start_z);
      t_in[0] = DFW'(center_x) - DFW'(seg_start_x);
      t_in[1] = DFW'(center_y) - DFW'(seg_start_y);
      t_in[2] = DFW'(center_z) - DFW'(seg_start_z);
      u_in[0] = DFW'(center_x) - DFW'(seg_end_x);
      u_in[1] = DFW'(center_y) - DFW'(seg_end_y);
      u_in[2] = DFW'(center_z) - DFW'(seg_end_z);
      r1_in   = radius;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         d_ff  <= d_in;
         t_ff  <= t_in;
         u_ff  <= u_in;
         r1_ff <= r1_in;
      end
   end

   // Stage 2: every elementary product, one multiplier deep.
   logic signed [PW-1:0]  xa_ff [3], xa_in [3];
   logic signed [PW-1:0]  xb_ff [3], xb_in [3];
   logic signed [PW-1:0]  pd_ff [3], pd_in [3];
   logic signed [PW-1:0]  qd_ff [3], qd_in [3];
   logic signed [PW-1:0]  dd_ff [3], dd_in [3];
   logic signed [PW-1:0]  tt_ff [3], tt_in [3];
   logic signed [PW-1:0]  uu_ff [3], uu_in [3];
   logic [R2W-1:0]        r2_2_ff, r2_2_in;
   flags_type             fl2_ff, fl2_in;

   always_comb begin
      xa_in[0] = d_ff[1] * t_ff[2];
      xb_in[0] = d_ff[2] * t_ff[1];
      xa_in[1] = d_ff[2] * t_ff[0];
      xb_in[1] = d_ff[0] * t_ff[2];
      xa_in[2] = d_ff[0] * t_ff[1];
      xb_in[2] = d_ff[1] * t_ff[0];
      for (int i = 0; i < 3; i++) begin
         pd_in[i] = t_ff[i] * d_ff[i];
         qd_in[i] = u_ff[i] * d_ff[i];
         dd_in[i] = d_ff[i] * d_ff[i];
         tt_in[i] = t_ff[i] * t_ff[i];
         uu_in[i] = u_ff[i] * u_ff[i];
      end
      r2_2_in          = R2W'(r1_ff) * R2W'(r1_ff);
      fl2_in           = '0;
      fl2_in.d_zero    = (d_ff[0] == '0) && (d_ff[1] == '0) && (d_ff[2] == '0);
      fl2_in.r_nonzero = (r1_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         xa_ff   <= xa_in;
         xb_ff   <= xb_in;
         pd_ff   <= pd_in;
         qd_ff   <= qd_in;
         dd_ff   <= dd_in;
         tt_ff   <= tt_in;
         uu_ff   <= uu_in;
         r2_2_ff <= r2_2_in;
         fl2_ff  <= fl2_in;
      end
   end

   // Stage 3: cross product components, dot products and squared lengths.
   logic signed [KSW-1:0] k_ff [3], k_in [3];
   logic signed [SW-1:0]  p_ff, p_in;
   logic signed [SW-1:0]  q_ff, q_in;
   logic [DW-1:0]         ds3_ff, ds3_in;
   logic [DW-1:0]         ts_ff, ts_in;
   logic [DW-1:0]         us_ff, us_in;
   logic [R2W-1:0]        r2_3_ff;
   flags_type             fl3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         k_in[i] = KSW'(xa_ff[i]) - KSW'(xb_ff[i]);
      end
      p_in   = SW'(pd_ff[0]) + SW'(pd_ff[1]) + SW'(pd_ff[2]);
      q_in   = SW'(qd_ff[0]) + SW'(qd_ff[1]) + SW'(qd_ff[2]);
      // Squares are never negative and their sums fit DW bits.
      ds3_in = DW'(dd_ff[0]) + DW'(dd_ff[1]) + DW'(dd_ff[2]);
      ts_in  = DW'(tt_ff[0]) + DW'(tt_ff[1]) + DW'(tt_ff[2]);
      us_in  = DW'(uu_ff[0]) + DW'(uu_ff[1]) + DW'(uu_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         k_ff    <= k_in;
         p_ff    <= p_in;
         q_ff    <= q_in;
         ds3_ff  <= ds3_in;
         ts_ff   <= ts_in;
         us_ff   <= us_in;
         r2_3_ff <= r2_2_ff;
         fl3_ff  <= fl2_ff;
      end
   end

   // Stage 4: cross magnitudes, projection test and endpoint-inside test.
   logic [KW-1:0]  km_ff [3], km_in [3];
   logic [DW-1:0]  ds4_ff;
   logic [R2W-1:0] r2_4_ff;
   flags_type      fl4_ff, fl4_in;
   logic           p_neg, p_zero, q_neg, q_zero;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         km_in[i] = k_ff[i][KSW-1] ? KW'(-k_ff[i]) : KW'(k_ff[i]);
      end
      p_neg  = p_ff[SW-1];
      p_zero = (p_ff == '0);
      q_neg  = q_ff[SW-1];
      q_zero = (q_ff == '0);
      fl4_in         = fl3_ff;
      // Opposite signs of the two dot products, or either one zero.
      fl4_in.proj_in = ((p_neg || p_zero) && !q_neg) || (!p_neg && (q_neg || q_zero));
      fl4_in.end_in  = (EW'(ts_ff) < EW'(r2_3_ff)) || (EW'(us_ff) < EW'(r2_3_ff));
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         km_ff   <= km_in;
         ds4_ff  <= ds3_ff;
         r2_4_ff <= r2_3_ff;
         fl4_ff  <= fl4_in;
      end
   end

   // Stage 5: half-width partial products of the squares and the radius limit.
   logic [2*KL-1:0]    pll_ff [3], pll_in [3];
   logic [KL+KH-1:0]   plh_ff [3], plh_in [3];
   logic [2*KH-1:0]    phh_ff [3], phh_in [3];
   logic [R2W+DL-1:0]  ml_ff, ml_in;
   logic [R2W+DH-1:0]  mh_ff, mh_in;
   flags_type          fl5_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pll_in[i] = (2*KL)'(km_ff[i][KL-1:0]) * (2*KL)'(km_ff[i][KL-1:0]);
         plh_in[i] = (KL+KH)'(km_ff[i][KL-1:0]) * (KL+KH)'(km_ff[i][KW-1:KL]);
         phh_in[i] = (2*KH)'(km_ff[i][KW-1:KL]) * (2*KH)'(km_ff[i][KW-1:KL]);
      end
      ml_in = (R2W+DL)'(r2_4_ff) * (R2W+DL)'(ds4_ff[DL-1:0]);
      mh_in = (R2W+DH)'(r2_4_ff) * (R2W+DH)'(ds4_ff[DW-1:DL]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         pll_ff <= pll_in;
         plh_ff <= plh_in;
         phh_ff <= phh_in;
         ml_ff  <= ml_in;
         mh_ff  <= mh_in;
         fl5_ff <= fl4_ff;
      end
   end

   // Stage 6: recombine the partial products.
   logic [QW-1:0] sq_ff [3], sq_in [3];
   logic [LW-1:0] lim6_ff, lim6_in;
   flags_type     fl6_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (QW'(phh_ff[i]) << (2 * KL)) + (QW'(plh_ff[i]) << (KL + 1))
                  + QW'(pll_ff[i]);
      end
      lim6_in = (LW'(mh_ff) << DL) + LW'(ml_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         sq_ff   <= sq_in;
         lim6_ff <= lim6_in;
         fl6_ff  <= fl5_ff;
      end
   end

   // Stage 7: squared length of the cross product.
   logic [C2W-1:0] c2_ff, c2_in;
   logic [LW-1:0]  lim7_ff;
   flags_type      fl7_ff;

   assign c2_in = C2W'(sq_ff[0]) + C2W'(sq_ff[1]) + C2W'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         c2_ff   <= c2_in;
         lim7_ff <= lim6_ff;
         fl7_ff  <= fl6_ff;
      end
   end

   // Stage 8: distance test against the radius and final decision.
   logic hit_ff, hit_in;
   logic too_far;

   always_comb begin
      too_far = (CW'(c2_ff) >= CW'(lim7_ff));
      if (fl7_ff.d_zero) begin
         hit_in = fl7_ff.r_nonzero;
      end else begin
         hit_in = !too_far && (fl7_ff.proj_in || fl7_ff.end_in);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

>>> hdl/segment_sphere_hit_test_top.sv
// Channel | Dir | Fields
// req_if  | in  | seg_start_x/y/z, seg_end_x/y/z, center_x/y/z, radius
// rsp_if  | out | hit
//
// One transaction is accepted per cycle while the first stage can load. A result
// is presented on rsp_if when its request transaction has passed through the
// eight-stage arithmetic pipeline.
// Reset is synchronous and clears only the stage valid bits.
// Each stage holds while its successor is full and stalled; empty stages keep
// filling, so the pipeline still takes requests while a response waits.
module segment_sphere_hit_test_top #(
   parameter int COORD_BITS = sshit_pkg::COORD_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   sshit_req_if.sink   req_if,
   sshit_rsp_if.source rsp_if
);
   import sshit_pkg::*;

   logic [PIPE_STAGES-1:0] valid_ff, valid_in;
   logic [PIPE_STAGES-1:0] stage_rdy;
   logic [PIPE_STAGES-1:0] prev_valid;

   // A stage may load when it is empty or its content moves on this cycle.
   always_comb begin
      stage_rdy[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || rsp_if.ready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         stage_rdy[i] = !valid_ff[i] || stage_rdy[i+1];
      end
   end

   // Valid bits travel alongside the data.
   always_comb begin
      prev_valid = {valid_ff[PIPE_STAGES-2:0], req_if.valid};
      for (int i = 0; i < PIPE_STAGES; i++) begin
         valid_in[i] = stage_rdy[i] ? prev_valid[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_if.ready = stage_rdy[0];
   assign rsp_if.valid = valid_ff[PIPE_STAGES-1];

   sshit_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .stage_en    (stage_rdy),
      .seg_start_x (req_if.seg_start_x),
      .seg_start_y (req_if.seg_start_y),
      .seg_start_z (req_if.seg_start_z),
      .seg_end_x   (req_if.seg_end_x),
      .seg_end_y   (req_if.seg_end_y),
      .seg_end_z   (req_if.seg_end_z),
      .center_x    (req_if.center_x),
      .center_y    (req_if.center_y),
      .center_z    (req_if.center_z),
      .radius      (req_if.radius),
      .hit         (rsp_if.hit)
   );

`ifndef ASSERT_OFF
   // An accepted request transaction occupies the first stage next cycle.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> valid_ff[0])
      else $error("accepted request did not enter the pipeline");

   // A blocked first stage keeps its transaction.
   a_first_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[0] && !stage_rdy[0]) |=> valid_ff[0])
      else $error("first stage dropped a stalled transaction");

   // A full pipeline behind a stalled response must not take a request.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_if.ready) |-> !req_if.ready)
      else $error("request accepted into a full stalled pipeline");

   // During a response stall, requests are taken only while a bubble remains.
   a_bubble_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready && req_if.ready) |-> !(&valid_ff))
      else $error("ready raised without a free stage");

   // Reset empties the pipeline.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not empty after reset");
`endif

endmodule
